FILE: rtl/assert_macros.svh
// Assertion macros shared by the desk height frame decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted.
`define HDF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HDF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define HDF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define HDF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: rtl/hdf_pkg.sv
// Types, constants and the seven-segment decode shared by the decoder.
package hdf_pkg;

    localparam int RX_W       = 8;
    localparam int HEIGHT_W   = 14;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [RX_W-1:0] START_MARKER_RST = 8'h9B;
    localparam logic [RX_W-1:0] HEIGHT_KIND_RST  = 8'h12;

    // Register index codes (byte address bit 2).
    localparam logic REG_START_MARKER = 1'b0;
    localparam logic REG_HEIGHT_KIND  = 1'b1;

    // Decimal point flag sits in bit 7 of the second data byte.
    localparam int DP_BIT = 7;

    localparam logic [HEIGHT_W-1:0] HEIGHT_MIN = 14'd100;
    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = 14'd9990;

    // Largest data count held in the data phase: length 255 closes at 254.
    localparam logic [RX_W-1:0] DATA_COUNT_MAX = 8'd253;

    // Seven-segment patterns with the point bit cleared.
    localparam logic [6:0] SEG_0 = 7'h3F;
    localparam logic [6:0] SEG_1 = 7'h06;
    localparam logic [6:0] SEG_2 = 7'h5B;
    localparam logic [6:0] SEG_3 = 7'h4F;
    localparam logic [6:0] SEG_4 = 7'h66;
    localparam logic [6:0] SEG_5 = 7'h6D;
    localparam logic [6:0] SEG_6 = 7'h7D;
    localparam logic [6:0] SEG_7 = 7'h07;
    localparam logic [6:0] SEG_8 = 7'h7F;
    localparam logic [6:0] SEG_9 = 7'h6F;

    typedef enum logic [1:0] {
        PH_WAIT,
        PH_LEN,
        PH_KIND,
        PH_DATA
    } phase_t;

    typedef logic [3:0] digit_t;

    typedef struct packed {
        logic [RX_W-1:0] start_marker;
        logic [RX_W-1:0] height_frame_kind;
    } cfg_t;

    // Closed frame handed from the framer to the output stage.
    typedef struct packed {
        logic            ok;
        logic [RX_W-1:0] seg0;
        logic [RX_W-1:0] seg1;
        logic [RX_W-1:0] seg2;
    } close_req_t;

    function automatic digit_t seg_digit(input logic [6:0] pattern);
        digit_t d;
        case (pattern)
            SEG_0:   d = 4'd0;
            SEG_1:   d = 4'd1;
            SEG_2:   d = 4'd2;
            SEG_3:   d = 4'd3;
            SEG_4:   d = 4'd4;
            SEG_5:   d = 4'd5;
            SEG_6:   d = 4'd6;
            SEG_7:   d = 4'd7;
            SEG_8:   d = 4'd8;
            SEG_9:   d = 4'd9;
            default: d = 4'd0;
        endcase
        return d;
    endfunction

endpackage

FILE: rtl/hdf_rx_if.sv
// Valid/ready channel carrying one received serial byte.
interface hdf_rx_if
    import hdf_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [RX_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: rtl/hdf_height_if.sv
// Valid/ready channel carrying one decoded desk height.
interface hdf_height_if
    import hdf_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [HEIGHT_W-1:0] height_tenths;

    modport source (output valid, output height_tenths, input ready);
    modport sink   (input valid, input height_tenths, output ready);
endinterface

FILE: rtl/desk_height_frame_decoder_top.sv
// Top level of the desk height frame decoder: APB registers, framer, output stage.
// Throughput: one received byte accepted every cycle while results are taken.
// The byte that closes a height frame yields its result through the
// closed-frame register, then the output register.
// Other bytes produce no result; a stalled output holds one result and one
// closed frame before the input stalls.
// Reset (rst_n, asynchronous, active low) clears frame tracking and loads register reset values.
module desk_height_frame_decoder_top
    import hdf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    hdf_rx_if.sink                rx,
    hdf_height_if.source          height,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // Live configuration; write it only while the decoder is idle (the block does not enforce this).
    cfg_t       cfg;

    // Closed-frame request between the framer and the output stage.
    logic       req_valid;
    logic       req_ready;
    close_req_t req;

    hdf_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Track marker, length, kind and data bytes; hand on each closed frame.
    hdf_framer u_framer (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx),
        .cfg       (cfg),
        .req_valid (req_valid),
        .req       (req),
        .req_ready (req_ready)
    );

    // Decode the three digits, drop blank or unchanged heights, hold the result.
    hdf_height_out u_height_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .req_ready (req_ready),
        .height    (height)
    );

endmodule

FILE: rtl/hdf_cfg_regs.sv
// APB configuration registers: start marker and height frame kind.
module hdf_cfg_regs
    import hdf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (paddr[2])
                REG_START_MARKER: cfg_next.start_marker      = pwdata[RX_W-1:0];
                REG_HEIGHT_KIND:  cfg_next.height_frame_kind = pwdata[RX_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_marker      <= START_MARKER_RST;
            cfg_reg.height_frame_kind <= HEIGHT_KIND_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_START_MARKER: prdata = {{(APB_DATA_W-RX_W){1'b0}}, cfg_reg.start_marker};
            REG_HEIGHT_KIND:  prdata = {{(APB_DATA_W-RX_W){1'b0}}, cfg_reg.height_frame_kind};
            default:          prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/hdf_framer.sv
// Frame parser: tracks marker, length, kind and data bytes, registers closed frames.
`include "assert_macros.svh"

module hdf_framer
    import hdf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    hdf_rx_if.sink        rx,
    input  cfg_t          cfg,
    output logic          req_valid,
    output close_req_t    req,
    input  logic          req_ready
);

    phase_t          phase_reg, phase_next;
    logic [RX_W-1:0] len_reg, len_next;
    logic [RX_W-1:0] kind_reg, kind_next;
    logic [RX_W-1:0] count_reg, count_next;
    logic [RX_W-1:0] seg_reg [3];
    logic [RX_W-1:0] seg_next [3];
    logic            req_valid_reg, req_valid_next;
    close_req_t      req_reg, req_next;

    logic            accept;
    logic [RX_W:0]   count_inc;
    logic [RX_W:0]   need;
    logic            close;

    assign rx.ready  = !req_valid_reg || req_ready;
    assign accept    = rx.valid && rx.ready;

    assign count_inc = {1'b0, count_reg} + 9'd1;
    // Lengths of zero or one still close after a single data byte.
    assign need      = (len_reg <= 8'd1) ? 9'd1 : ({1'b0, len_reg} - 9'd1);
    assign close     = (phase_reg == PH_DATA) && (count_inc >= need);

    // Next state of the frame tracker.
    always_comb
    begin
        phase_next = phase_reg;
        len_next   = len_reg;
        kind_next  = kind_reg;
        count_next = count_reg;
        for (int i = 0; i < 3; i++)
        begin
            seg_next[i] = seg_reg[i];
        end
        if (accept)
        begin
            case (phase_reg)
                PH_WAIT:
                begin
                    if (rx.rx_byte == cfg.start_marker)
                    begin
                        phase_next = PH_LEN;
                        count_next = '0;
                    end
                end
                PH_LEN:
                begin
                    len_next   = rx.rx_byte;
                    phase_next = PH_KIND;
                end
                PH_KIND:
                begin
                    kind_next  = rx.rx_byte;
                    phase_next = PH_DATA;
                end
                PH_DATA:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        if (count_reg == RX_W'(i))
                        begin
                            seg_next[i] = rx.rx_byte;
                        end
                    end
                    count_next = count_inc[RX_W-1:0];
                    if (close)
                    begin
                        phase_next = PH_WAIT;
                    end
                end
                default:
                begin
                    phase_next = PH_WAIT;
                end
            endcase
        end
    end

    // Closed-frame request register.
    always_comb
    begin
        req_next       = req_reg;
        req_valid_next = req_valid_reg && !req_ready;
        if (accept && close)
        begin
            req_valid_next = 1'b1;
            req_next.ok    = (kind_reg == cfg.height_frame_kind) && (count_inc >= 9'd3);
            req_next.seg0  = seg_next[0];
            req_next.seg1  = seg_next[1];
            req_next.seg2  = seg_next[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_WAIT;
            req_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            req_valid_reg <= req_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg   <= len_next;
        kind_reg  <= kind_next;
        count_reg <= count_next;
        for (int i = 0; i < 3; i++)
        begin
            seg_reg[i] <= seg_next[i];
        end
        req_reg   <= req_next;
    end

    assign req_valid = req_valid_reg;
    assign req       = req_reg;

    `HDF_ASSERT_IMP(a_no_close_outside_data, clk, rst_n, phase_reg != PH_DATA, !close, "frame closed outside data phase")
    `HDF_ASSERT_NXT(a_close_returns_to_wait, clk, rst_n, accept && close, phase_reg == PH_WAIT && req_valid_reg, "closed frame not handed on")
    `HDF_ASSERT_IMP(a_count_bounded, clk, rst_n, phase_reg == PH_DATA, count_reg <= DATA_COUNT_MAX, "data count passed frame length")

endmodule

FILE: rtl/hdf_height_out.sv
// Digit decode, change filter and output register for decoded heights.
`include "assert_macros.svh"

module hdf_height_out
    import hdf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  close_req_t    req,
    output logic          req_ready,
    hdf_height_if.source  height
);

    digit_t              d1, d2, d3;
    logic [9:0]          value;
    logic [HEIGHT_W-1:0] h;
    logic                hit;
    logic                load;
    logic                out_ready;

    logic                out_valid_reg, out_valid_next;
    logic [HEIGHT_W-1:0] out_height_reg, out_height_next;
    logic [HEIGHT_W-1:0] last_height_reg, last_height_next;
    logic                known_reg, known_next;

    assign d1    = seg_digit(req.seg0[6:0]);
    assign d2    = seg_digit(req.seg1[6:0]);
    assign d3    = seg_digit(req.seg2[6:0]);
    assign value = 10'(d1) * 10'd100 + 10'(d2) * 10'd10 + 10'(d3);
    assign h     = req.seg1[DP_BIT] ? HEIGHT_W'(value) : HEIGHT_W'(value) * 14'd10;

    // Blank display and repeated heights give no result.
    assign hit = req.ok && (req.seg0 != '0) && (d1 != '0)
                 && (!known_reg || (last_height_reg != h));

    assign out_ready = height.ready;
    assign req_ready = !hit || !out_valid_reg || out_ready;
    assign load      = req_valid && hit && req_ready;

    always_comb
    begin
        out_valid_next   = out_valid_reg && !out_ready;
        out_height_next  = out_height_reg;
        last_height_next = last_height_reg;
        known_next       = known_reg;
        if (load)
        begin
            out_valid_next   = 1'b1;
            out_height_next  = h;
            last_height_next = h;
            known_next       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            known_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            known_reg     <= known_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_height_reg  <= out_height_next;
        last_height_reg <= last_height_next;
    end

    assign height.valid         = out_valid_reg;
    assign height.height_tenths = out_height_reg;

    `HDF_ASSERT_IMP(a_height_in_range, clk, rst_n, out_valid_reg, out_height_reg >= HEIGHT_MIN && out_height_reg <= HEIGHT_MAX, "height out of range")
    `HDF_ASSERT_NXT(a_last_tracks_out, clk, rst_n, load, known_reg && last_height_reg == out_height_reg, "last height not updated")
    `HDF_ASSERT_IMP(a_valid_implies_known, clk, rst_n, out_valid_reg, known_reg, "result without known height")

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the desk height frame decoder: random framed byte streams against a built-in tracker.
`timescale 1ns / 1ps

module testbench;

    import hdf_pkg::*;

    localparam int CLK_PERIOD  = 2;
    localparam int RESET_CYCLES = 9;
    // Long enough for the output stage and the closed-frame register to fill and stall rx.
    localparam int LONG_HOLD    = 200;
    // Closing byte -> closed-frame register -> output register, plus margin.
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_LIMIT  = 2000;
    localparam int TIMEOUT_NS   = 1_000_000;

    // Seven-segment patterns indexed by digit value (bit 7 excluded).
    localparam logic [9:0][6:0] SEG_TABLE = {SEG_9, SEG_8, SEG_7, SEG_6, SEG_5,
                                             SEG_4, SEG_3, SEG_2, SEG_1, SEG_0};

    logic clk = 1'b0;
    logic rst_n;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    hdf_rx_if     rx_ch();
    hdf_height_if height_ch();

    desk_height_frame_decoder_top i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx_ch),
        .height  (height_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Frame tracker: mirrors the decoder's register and frame state and
    // works out the height each accepted byte should produce.
    // ------------------------------------------------------------------
    logic [RX_W-1:0]     cfg_marker = START_MARKER_RST;
    logic [RX_W-1:0]     cfg_kind   = HEIGHT_KIND_RST;

    phase_t              trk_phase  = PH_WAIT;
    logic [RX_W-1:0]     trk_len    = '0;
    logic [RX_W-1:0]     trk_kind   = '0;
    logic [RX_W-1:0]     trk_count  = '0;
    logic [2:0][RX_W-1:0] trk_segs  = '0;
    logic [HEIGHT_W-1:0] trk_last   = '0;
    bit                  trk_known  = 1'b0;

    // Heights still owed by the decoder, oldest first.
    logic [HEIGHT_W-1:0] heights_due[$];

    int unsigned bytes_sent = 0;
    int unsigned mismatch_count = 0;

    // Idling controls: a quiet side never waits between requests.
    bit send_quiet = 1'b0;
    bit sink_quiet = 1'b0;
    // Long receiver hold-offs: the test raises the request count, the sink serves it.
    int unsigned long_hold_pending = 0;
    int unsigned long_hold_served  = 0;

    logic [2:0][RX_W-1:0] prev_segs = '0;
    logic [HEIGHT_W-1:0]  got_expected;

    // Digit shown by a pattern; anything unrecognised reads as 0.
    function automatic int unsigned digit_of(input logic [RX_W-1:0] pattern);
        for (int d = 1; d < 10; d++)
            if (pattern[6:0] == SEG_TABLE[d])
                return d;
        return 0;
    endfunction

    // Advance the tracker by one byte; emit is set when a new height is due.
    function automatic void track_byte(input logic [RX_W-1:0] b, output bit emit,
                                       output logic [HEIGHT_W-1:0] height_out);
        int unsigned cnt;
        int unsigned need;
        int unsigned val;
        int unsigned hv;
        emit = 1'b0;
        height_out = '0;
        case (trk_phase)
            PH_WAIT:
            begin
                if (b == cfg_marker)
                begin
                    trk_phase = PH_LEN;
                    trk_count = '0;
                end
                return;
            end
            PH_LEN:
            begin
                trk_len = b;
                trk_phase = PH_KIND;
                return;
            end
            PH_KIND:
            begin
                trk_kind = b;
                trk_phase = PH_DATA;
                return;
            end
            default:
            begin
            end
        endcase

        // Data bytes past the third are counted but not kept.
        if (trk_count < 3)
            trk_segs[trk_count] = b;
        cnt = trk_count + 1;
        trk_count = cnt[RX_W-1:0];
        need = (trk_len <= 1) ? 1 : trk_len - 1;
        if (cnt < need)
            return;

        trk_phase = PH_WAIT;
        // Drop frames of another kind, short frames and a blank display.
        if (trk_kind != cfg_kind || cnt < 3 || trk_segs[0] == '0)
            return;
        if (digit_of(trk_segs[0]) == 0)
            return;
        val = digit_of(trk_segs[0]) * 100 + digit_of(trk_segs[1]) * 10
              + digit_of(trk_segs[2]);
        hv = trk_segs[1][DP_BIT] ? val : val * 10;
        if (trk_known && trk_last == hv[HEIGHT_W-1:0])
            return;
        trk_last = hv[HEIGHT_W-1:0];
        trk_known = 1'b1;
        emit = 1'b1;
        height_out = hv[HEIGHT_W-1:0];
    endfunction

    // Pattern for a digit with a random point bit.
    function automatic logic [RX_W-1:0] seg_byte(input int unsigned d);
        logic top;
        top = 1'($urandom_range(0, 1));
        return {top, SEG_TABLE[d]};
    endfunction

    // ------------------------------------------------------------------
    // Byte sender: wait a drawn gap, offer the request, hold it until the
    // decoder takes it, then log the height it should cause.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [RX_W-1:0] b);
        int unsigned gap;
        bit emit;
        logic [HEIGHT_W-1:0] h;
        gap = send_quiet ? 0 : $urandom_range(0, 15);
        if (gap != 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do
            @(posedge clk);
        while (rx_ch.ready !== 1'b1);
        track_byte(b, emit, h);
        if (emit)
            heights_due = {heights_due, h};
        bytes_sent++;
    endtask

    // Drop the request line and wait for every owed height.
    task automatic wait_drain();
        rx_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (heights_due.size() != 0);
    endtask

    // Marker, length, kind, then as many data bytes as the length calls for.
    task automatic send_frame_bytes(input logic [RX_W-1:0] len_b, kind_b, s0, s1, s2);
        int unsigned need;
        need = (len_b <= 8'd1) ? 1 : len_b - 1;
        send_byte(cfg_marker);
        send_byte(len_b);
        send_byte(kind_b);
        for (int unsigned i = 0; i < need; i++)
            send_byte(i == 0 ? s0 : i == 1 ? s1 : i == 2 ? s2 : 8'($urandom));
    endtask

    // Mostly well-formed height frames with random content, the rest
    // noise, broken frames, odd lengths and foreign kinds.
    task automatic send_frame();
        logic [RX_W-1:0]      len_b;
        logic [RX_W-1:0]      kind_b;
        logic [2:0][RX_W-1:0] segs;
        int unsigned          pick;
        if ($urandom_range(0, 7) == 0)
            send_quiet = !send_quiet;
        if ($urandom_range(0, 5) == 0)
            send_byte(8'($urandom));
        if ($urandom_range(0, 15) == 0)
        begin
            // Broken frame: the next marker lands in the kind slot.
            send_byte(cfg_marker);
            send_byte(8'($urandom));
            return;
        end
        pick = $urandom_range(0, 199);
        if (pick < 130)
            len_b = 8'd4;
        else if (pick < 165)
            len_b = 8'($urandom_range(5, 8));
        else if (pick < 188)
            len_b = 8'($urandom_range(0, 3));
        else if (pick < 199)
            len_b = 8'($urandom_range(9, 40));
        else
            len_b = $urandom_range(0, 1) ? 8'd255 : 8'($urandom_range(200, 254));
        kind_b = ($urandom_range(0, 7) == 0) ? 8'($urandom) : cfg_kind;
        // Repeat the last display now and then so unchanged heights occur.
        if ($urandom_range(0, 4) == 0)
            segs = prev_segs;
        else
            for (int i = 0; i < 3; i++)
                segs[i] = ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                      : seg_byte($urandom_range(0, 9));
        prev_segs = segs;
        send_frame_bytes(len_b, kind_b, segs[0], segs[1], segs[2]);
    endtask

    // ------------------------------------------------------------------
    // Register access: only with the decoder idle. Write, read back, and
    // update the tracker's copy.
    // ------------------------------------------------------------------
    task automatic apb_access(input logic wr, input logic reg_idx, input logic [RX_W-1:0] value);
        logic [23:0] noise;
        noise = 24'($urandom);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= {noise, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        if (!wr && prdata !== {24'b0, value})
        begin
            $display("%0t: register %0d read expected %0h got %0h",
                     $realtime, reg_idx, {24'b0, value}, prdata);
            mismatch_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // Hold the bus idle between accesses.
        @(posedge clk);
    endtask

    task automatic write_reg(input logic reg_idx, input logic [RX_W-1:0] value);
        wait_drain();
        // A closing byte that yields nothing may still be in flight.
        repeat (SETTLE_CYCLES) @(posedge clk);
        apb_access(1'b1, reg_idx, value);
        apb_access(1'b0, reg_idx, value);
        if (reg_idx == REG_START_MARKER)
            cfg_marker = value;
        else
            cfg_kind = value;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_register_reset();
        apb_access(1'b0, REG_START_MARKER, START_MARKER_RST);
        apb_access(1'b0, REG_HEIGHT_KIND, HEIGHT_KIND_RST);
    endtask

    task automatic test_directed_frames();
        // Stray byte while hunting for the marker.
        send_byte(8'h00);
        // Length zero closes after one data byte and is too short to decode.
        send_frame_bytes(8'd0, cfg_kind, SEG_TABLE[1], 8'hff, 8'hff);
        // Largest height, no point, one extra data byte counted but not kept.
        send_frame_bytes(8'd5, cfg_kind, SEG_TABLE[9], SEG_TABLE[9], SEG_TABLE[9]);
        // Frame of another kind.
        send_frame_bytes(8'd4, 8'hff, SEG_TABLE[1], SEG_TABLE[1], SEG_TABLE[1]);
        // Blank display: first data byte zero.
        send_frame_bytes(8'd4, cfg_kind, 8'h00, SEG_TABLE[2], SEG_TABLE[2]);
        // Smallest height: point set, bit 7 on the first digit, unknown third pattern.
        send_frame_bytes(8'd4, cfg_kind, {1'b1, SEG_TABLE[1]}, {1'b1, SEG_TABLE[0]}, 8'h80);
        // Same display again: no new height.
        send_frame_bytes(8'd4, cfg_kind, {1'b1, SEG_TABLE[1]}, {1'b1, SEG_TABLE[0]}, 8'h80);
    endtask

    task automatic run_setting(input logic [RX_W-1:0] marker, kind_b, input int unsigned n);
        int unsigned stop_at;
        write_reg(REG_START_MARKER, marker);
        write_reg(REG_HEIGHT_KIND, kind_b);
        stop_at = bytes_sent + n;
        while (bytes_sent < stop_at)
            send_frame();
    endtask

    task automatic test_register_settings();
        logic [RX_W-1:0] pick;
        pick = 8'($urandom);
        run_setting(8'h00, 8'hff, 100);
        run_setting(8'hff, 8'h00, 100);
        // Marker and kind equal.
        run_setting(pick, pick, 100);
        run_setting(8'($urandom), 8'($urandom), 100);
        run_setting(START_MARKER_RST, HEIGHT_KIND_RST, 100);
    endtask

    task automatic test_random_frames();
        int unsigned stop_at;
        stop_at = bytes_sent + 900;
        while (bytes_sent < stop_at)
            send_frame();
    endtask

    // Hold the sink off for a long stretch while height frames stream in
    // back to back, so the output stage fills and rx stalls.
    task automatic test_output_backpressure();
        send_quiet = 1'b1;
        long_hold_pending++;
        for (int unsigned k = 0; k < 20; k++)
            send_frame_bytes(8'd4, cfg_kind, seg_byte(1 + k % 9),
                             seg_byte($urandom_range(0, 9)), seg_byte($urandom_range(0, 9)));
        send_quiet = 1'b0;
    endtask

    // Pause the sender until every owed height has been taken, then resume.
    task automatic test_sender_pause();
        int unsigned stop_at;
        repeat (3)
        begin
            stop_at = bytes_sent + 40;
            while (bytes_sent < stop_at)
                send_frame();
            wait_drain();
        end
    endtask

    // ------------------------------------------------------------------
    // Result sink: draw a stall per request, serve long hold-offs, and
    // occasionally switch to taking results without a break.
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int unsigned wait_n;
        height_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (long_hold_served != long_hold_pending)
            begin
                long_hold_served++;
                height_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            if ($urandom_range(0, 15) == 0)
                sink_quiet = !sink_quiet;
            wait_n = sink_quiet ? 0 : $urandom_range(0, 15);
            if (wait_n != 0)
            begin
                height_ch.ready <= 1'b0;
                repeat (wait_n) @(posedge clk);
            end
            height_ch.ready <= 1'b1;
            // Leave early for a long hold-off request; no transfer happened then.
            do
                @(posedge clk);
            while (height_ch.valid !== 1'b1 && long_hold_served == long_hold_pending);
        end
    end

    // Compare every accepted height with the oldest one owed.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && height_ch.valid === 1'b1 && height_ch.ready === 1'b1)
        begin
            if (heights_due.size() == 0)
            begin
                $display("%0t: height_tenths expected none got %0d",
                         $realtime, height_ch.height_tenths);
                mismatch_count++;
            end
            else
            begin
                got_expected = heights_due.pop_front();
                if (height_ch.height_tenths !== got_expected)
                begin
                    $display("%0t: height_tenths expected %0d got %0d",
                             $realtime, got_expected, height_ch.height_tenths);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_reset();
        test_directed_frames();
        test_register_settings();
        test_random_frames();
        test_output_backpressure();
        test_sender_pause();

        // Let the last heights out, bounded, then watch for strays.
        rx_ch.valid <= 1'b0;
        for (int n = 0; n < DRAIN_LIMIT && heights_due.size() != 0; n++)
            @(posedge clk);
        if (heights_due.size() != 0)
        begin
            $display("%0t: height_tenths expected %0d got none (%0d outstanding)",
                     $realtime, heights_due[0], heights_due.size());
            mismatch_count++;
        end
        repeat (SETTLE_CYCLES * 2) @(posedge clk);

        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #(TIMEOUT_NS);
        $display("simulation failed");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/hdf_pkg.sv
rtl/hdf_rx_if.sv
rtl/hdf_height_if.sv
rtl/hdf_cfg_regs.sv
rtl/hdf_framer.sv
rtl/hdf_height_out.sv
rtl/desk_height_frame_decoder_top.sv
verif/testbench.sv
